@@ sv/mkcl_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mkcl_pkg
// Types and constants shared by the Morse key code lock.
// ----------------------------------------------------------------------------
package mkcl_pkg;

    localparam int unsigned MAX_CODE_DEF = 16;
    localparam int unsigned WIN_W        = 16;
    localparam int unsigned LEN_W        = 5;
    localparam int unsigned TICK_W       = 16;
    localparam int unsigned NOISE_W      = 8;
    localparam int unsigned CFG_IDX_W    = 3;
    localparam int unsigned CFG_DATA_W   = 16;
    localparam int unsigned IN_TDATA_W   = 8;
    localparam int unsigned OUT_TDATA_W  = 24;

    localparam logic [CFG_IDX_W-1:0] REG_OPEN_PATTERN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ADMIN_PATTERN   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CODE_LENGTH     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_TICKS      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_TICKS     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_DOT_BEEP_TICKS  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DASH_BEEP_TICKS = 3'd6;

    localparam logic [WIN_W-1:0]   RST_OPEN_PATTERN    = 16'd2854;
    localparam logic [WIN_W-1:0]   RST_ADMIN_PATTERN   = 16'd29913;
    localparam logic [LEN_W-1:0]   RST_CODE_LENGTH     = 5'd15;
    localparam logic [TICK_W-1:0]  RST_DASH_TICKS      = 16'd300;
    localparam logic [NOISE_W-1:0] RST_NOISE_TICKS     = 8'd10;
    localparam logic [TICK_W-1:0]  RST_DOT_BEEP_TICKS  = 16'd100;
    localparam logic [TICK_W-1:0]  RST_DASH_BEEP_TICKS = 16'd300;

    typedef enum logic [1:0] {
        MATCH_NONE  = 2'd0,
        MATCH_OPEN  = 2'd1,
        MATCH_ADMIN = 2'd2
    } t_match;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_NOISE   = 3'd1,
        PH_TIME    = 3'd2,
        PH_BEEP    = 3'd3,
        PH_RELEASE = 3'd4
    } t_phase;

endpackage

@@ sv/morse_key_code_lock.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_code_lock
// Times key presses into dots and dashes and matches them against two codes.
// ----------------------------------------------------------------------------
// Channel   Direction  Width  Contents
// s_axis    in         8      key_down in bit 0, one transfer per ms tick
// m_axis    out        24     beep, symbol flags, match code, symbol window
// cfg       in         16     write enable, register index, write data
//
// One tick is taken per clock cycle while s_axis_tready is high; its result
// appears in the output register on the next cycle, set by the single state
// update per tick. Reset is synchronous and returns the configuration and state
// registers to their reset values; s_axis_tready is low while reset is held.
// A result not yet taken holds s_axis_tready low only if m_axis_tready is low.
// ----------------------------------------------------------------------------
module morse_key_code_lock #(
    parameter int unsigned MAX_CODE = mkcl_pkg::MAX_CODE_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // [0] key_down, [7:1] zero
    input  logic [mkcl_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // [0] beep_on, [1] symbol_valid, [2] symbol_is_dash, [4:3] match_code,
    // [20:5] window_bits, [23:21] zero
    output logic [mkcl_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    input  logic                               i_cfg_we,
    input  logic [mkcl_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [mkcl_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int unsigned WIN_W  = mkcl_pkg::WIN_W;
    localparam int unsigned LEN_W  = mkcl_pkg::LEN_W;
    localparam int unsigned TICK_W = mkcl_pkg::TICK_W;
    localparam int unsigned LEN_CAP_I = (MAX_CODE < WIN_W) ? MAX_CODE : WIN_W;
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LEN_CAP_I);

    logic [WIN_W-1:0]            r_open_pattern, r_admin_pattern;
    logic [LEN_W-1:0]            r_code_length;
    logic [TICK_W-1:0]           r_dash_ticks, r_dot_beep_ticks, r_dash_beep_ticks;
    logic [mkcl_pkg::NOISE_W-1:0] r_noise_ticks;

    mkcl_pkg::t_phase            r_phase, n_phase;
    logic [TICK_W-1:0]           r_tick_count, n_tick_count;
    logic [WIN_W-1:0]            r_window, n_window;
    logic [LEN_W-1:0]            r_filled, n_filled;
    logic                        r_after_dash, n_after_dash;

    logic                        r_out_valid;
    logic                        r_beep, r_sym_valid, r_sym_dash;
    mkcl_pkg::t_match            r_match, n_match;

    logic                        key, accept;
    logic                        sym_valid, sym_dash, beep;
    logic [TICK_W-1:0]           held_inc, beep_len;
    logic [LEN_W-1:0]            eff_len;
    logic [WIN_W-1:0]            len_mask;

    assign key    = s_axis_tdata[0];
    assign accept = s_axis_tvalid & s_axis_tready;
    assign s_axis_tready = i_rst_n & (~r_out_valid | m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open_pattern    <= mkcl_pkg::RST_OPEN_PATTERN;
            r_admin_pattern   <= mkcl_pkg::RST_ADMIN_PATTERN;
            r_code_length     <= mkcl_pkg::RST_CODE_LENGTH;
            r_dash_ticks      <= mkcl_pkg::RST_DASH_TICKS;
            r_noise_ticks     <= mkcl_pkg::RST_NOISE_TICKS;
            r_dot_beep_ticks  <= mkcl_pkg::RST_DOT_BEEP_TICKS;
            r_dash_beep_ticks <= mkcl_pkg::RST_DASH_BEEP_TICKS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mkcl_pkg::REG_OPEN_PATTERN:    r_open_pattern    <= i_cfg_data;
                mkcl_pkg::REG_ADMIN_PATTERN:   r_admin_pattern   <= i_cfg_data;
                mkcl_pkg::REG_CODE_LENGTH:     r_code_length     <= i_cfg_data[LEN_W-1:0];
                mkcl_pkg::REG_DASH_TICKS:      r_dash_ticks      <= i_cfg_data;
                mkcl_pkg::REG_NOISE_TICKS:
                    r_noise_ticks <= i_cfg_data[mkcl_pkg::NOISE_W-1:0];
                mkcl_pkg::REG_DOT_BEEP_TICKS:  r_dot_beep_ticks  <= i_cfg_data;
                mkcl_pkg::REG_DASH_BEEP_TICKS: r_dash_beep_ticks <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_code_length == '0) begin
            eff_len = LEN_W'(1);
        end else if (r_code_length > LEN_CAP) begin
            eff_len = LEN_CAP;
        end else begin
            eff_len = r_code_length;
        end
    end

    assign len_mask = WIN_W'((17'd1 << eff_len) - 17'd1);
    assign held_inc = (r_tick_count == '1) ? r_tick_count : r_tick_count + TICK_W'(1);

    // Symbol detection and buzzer level for the current tick.
    always_comb begin
        sym_valid = 1'b0;
        sym_dash  = 1'b0;
        beep      = 1'b0;
        unique case (r_phase)
            mkcl_pkg::PH_TIME: begin
                if (key) begin
                    if (held_inc > r_dash_ticks) begin
                        sym_valid = 1'b1;
                        sym_dash  = 1'b1;
                    end
                end else begin
                    sym_valid = 1'b1;
                end
            end
            mkcl_pkg::PH_BEEP: beep = 1'b1;
            default: ;
        endcase
        beep_len = sym_dash ? r_dash_beep_ticks : r_dot_beep_ticks;
        if (sym_valid) begin
            beep = (beep_len != '0);
        end
    end

    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_window     = r_window;
        n_filled     = r_filled;
        n_after_dash = r_after_dash;
        n_match      = mkcl_pkg::MATCH_NONE;
        unique case (r_phase) inside
            mkcl_pkg::PH_IDLE: begin
                if (key) begin
                    if (r_noise_ticks == '0) begin
                        n_phase      = mkcl_pkg::PH_TIME;
                        n_tick_count = '0;
                    end else begin
                        n_phase      = mkcl_pkg::PH_NOISE;
                        n_tick_count = TICK_W'(r_noise_ticks);
                    end
                end
            end
            mkcl_pkg::PH_NOISE, mkcl_pkg::PH_BEEP: begin
                if (r_tick_count > TICK_W'(1)) begin
                    n_tick_count = r_tick_count - TICK_W'(1);
                end else begin
                    n_tick_count = '0;
                    if (r_phase == mkcl_pkg::PH_NOISE) begin
                        n_phase = mkcl_pkg::PH_TIME;
                    end else begin
                        n_phase = r_after_dash ? mkcl_pkg::PH_RELEASE : mkcl_pkg::PH_IDLE;
                    end
                end
            end
            mkcl_pkg::PH_TIME: begin
                if (key) begin
                    n_tick_count = held_inc;
                end
            end
            mkcl_pkg::PH_RELEASE: begin
                if (!key) begin
                    n_phase      = mkcl_pkg::PH_IDLE;
                    n_tick_count = '0;
                end
            end
            default: begin
                n_phase      = mkcl_pkg::PH_IDLE;
                n_tick_count = '0;
            end
        endcase

        if (sym_valid) begin
            n_window = {r_window[WIN_W-2:0], sym_dash} & len_mask;
            if (r_filled < eff_len) begin
                n_filled = r_filled + LEN_W'(1);
            end
            if (n_filled >= eff_len) begin
                if (n_window == (r_open_pattern & len_mask)) begin
                    n_match = mkcl_pkg::MATCH_OPEN;
                end else if (n_window == (r_admin_pattern & len_mask)) begin
                    n_match = mkcl_pkg::MATCH_ADMIN;
                end
            end
            n_after_dash = sym_dash;
            if (beep_len > TICK_W'(1)) begin
                n_tick_count = beep_len - TICK_W'(1);
                n_phase      = mkcl_pkg::PH_BEEP;
            end else begin
                n_tick_count = '0;
                n_phase      = sym_dash ? mkcl_pkg::PH_RELEASE : mkcl_pkg::PH_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= mkcl_pkg::PH_IDLE;
            r_tick_count <= '0;
            r_window     <= '0;
            r_filled     <= '0;
            r_after_dash <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (accept) begin
                r_phase      <= n_phase;
                r_tick_count <= n_tick_count;
                r_window     <= n_window;
                r_filled     <= n_filled;
                r_after_dash <= n_after_dash;
                r_out_valid  <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_beep      <= beep;
            r_sym_valid <= sym_valid;
            r_sym_dash  <= sym_dash;
            r_match     <= n_match;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_window, r_match, r_sym_dash, r_sym_valid, r_beep};

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= LEN_W'(WIN_W))
        else $error("symbol fill count beyond window width");

    a_beep_count_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == mkcl_pkg::PH_BEEP |-> r_tick_count != '0)
        else $error("beep phase with an empty tick count");

    a_quiet_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_sym_valid |-> !r_sym_dash && r_match == mkcl_pkg::MATCH_NONE)
        else $error("dash or match flagged without a symbol");

    a_symbol_ends_press: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && sym_valid |=> r_phase != mkcl_pkg::PH_TIME && r_phase != mkcl_pkg::PH_NOISE)
        else $error("press timing continued after a symbol");

endmodule

@@ tb/sv/morse_key_code_lock_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// morse_key_code_lock_tb
// Self-checking testbench for the Morse key code lock.
// Key levels are streamed in one per tick. A scoreboard predicts the beep, the
// symbol and the code match of every tick, and each output transfer is checked
// against it. Short directed presses are followed by randomised settings and
// code entries, a few long presses and beeps, and random idling on both
// streams.
// ----------------------------------------------------------------------------
module morse_key_code_lock_tb;

    localparam int unsigned WIN_W       = mkcl_pkg::WIN_W;
    localparam int unsigned LEN_W       = mkcl_pkg::LEN_W;
    localparam int unsigned TICK_W      = mkcl_pkg::TICK_W;
    localparam int unsigned NOISE_W     = mkcl_pkg::NOISE_W;
    localparam int unsigned CFG_IDX_W   = mkcl_pkg::CFG_IDX_W;
    localparam int unsigned CFG_DATA_W  = mkcl_pkg::CFG_DATA_W;
    localparam int unsigned IN_TDATA_W  = mkcl_pkg::IN_TDATA_W;
    localparam int unsigned OUT_TDATA_W = mkcl_pkg::OUT_TDATA_W;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned ITEM_TARGET = 1550;

    typedef struct packed {
        logic [WIN_W-1:0] window;
        mkcl_pkg::t_match code;
        logic             dash;
        logic             symbol;
        logic             beep;
    } t_tick_out;

    class lock_scoreboard;
        logic [WIN_W-1:0]   open_code, admin_code;
        logic [LEN_W-1:0]   code_len;
        logic [TICK_W-1:0]  dash_limit, dot_beep, dash_beep;
        logic [NOISE_W-1:0] noise_len;
        mkcl_pkg::t_phase   phase;
        logic [TICK_W-1:0]  ticks;
        logic [WIN_W-1:0]   window;
        logic [LEN_W-1:0]   filled;
        logic               last_dash;
        t_tick_out          pending[$];
        int unsigned        errors, ticks_checked, dots, dashes, opens, admins;

        function void reset();
            open_code  = mkcl_pkg::RST_OPEN_PATTERN;
            admin_code = mkcl_pkg::RST_ADMIN_PATTERN;
            code_len   = mkcl_pkg::RST_CODE_LENGTH;
            dash_limit = mkcl_pkg::RST_DASH_TICKS;
            noise_len  = mkcl_pkg::RST_NOISE_TICKS;
            dot_beep   = mkcl_pkg::RST_DOT_BEEP_TICKS;
            dash_beep  = mkcl_pkg::RST_DASH_BEEP_TICKS;
            phase      = mkcl_pkg::PH_IDLE;
            ticks      = '0;
            window     = '0;
            filled     = '0;
            last_dash  = 1'b0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                mkcl_pkg::REG_OPEN_PATTERN:    open_code  = data;
                mkcl_pkg::REG_ADMIN_PATTERN:   admin_code = data;
                mkcl_pkg::REG_CODE_LENGTH:     code_len   = data[LEN_W-1:0];
                mkcl_pkg::REG_DASH_TICKS:      dash_limit = data;
                mkcl_pkg::REG_NOISE_TICKS:     noise_len  = data[NOISE_W-1:0];
                mkcl_pkg::REG_DOT_BEEP_TICKS:  dot_beep   = data;
                mkcl_pkg::REG_DASH_BEEP_TICKS: dash_beep  = data;
                default: ;
            endcase
        endfunction

        function int unsigned code_span();
            int unsigned n;
            n = 32'(code_len);
            if (n < 1) n = 1;
            if (n > mkcl_pkg::MAX_CODE_DEF) n = mkcl_pkg::MAX_CODE_DEF;
            if (n > WIN_W) n = WIN_W;
            return n;
        endfunction

        function void note_key(logic key);
            t_tick_out   o;
            int unsigned n;
            logic [WIN_W-1:0]  mask;
            logic [TICK_W-1:0] blen;
            o = '0;
            case (phase)
                mkcl_pkg::PH_IDLE: if (key) begin
                    if (noise_len == 0) begin
                        phase = mkcl_pkg::PH_TIME;
                        ticks = '0;
                    end else begin
                        phase = mkcl_pkg::PH_NOISE;
                        ticks = TICK_W'(noise_len);
                    end
                end
                mkcl_pkg::PH_NOISE: begin
                    if (ticks != 0) ticks--;
                    if (ticks == 0) phase = mkcl_pkg::PH_TIME;
                end
                mkcl_pkg::PH_TIME: if (key) begin
                    if (ticks != '1) ticks++;
                    if (ticks > dash_limit) begin
                        o.symbol = 1'b1;
                        o.dash   = 1'b1;
                    end
                end else begin
                    o.symbol = 1'b1;
                end
                mkcl_pkg::PH_BEEP: begin
                    o.beep = 1'b1;
                    if (ticks != 0) ticks--;
                    if (ticks == 0) phase = last_dash ? mkcl_pkg::PH_RELEASE : mkcl_pkg::PH_IDLE;
                end
                mkcl_pkg::PH_RELEASE: if (!key) begin
                    phase = mkcl_pkg::PH_IDLE;
                    ticks = '0;
                end
                default: begin
                    phase = mkcl_pkg::PH_IDLE;
                    ticks = '0;
                end
            endcase
            if (o.symbol) begin
                n      = code_span();
                mask   = WIN_W'((32'd1 << n) - 1);
                blen   = o.dash ? dash_beep : dot_beep;
                window = ((window << 1) | {{(WIN_W-1){1'b0}}, o.dash}) & mask;
                if (filled < n) filled++;
                if (filled >= n) begin
                    if (window == (open_code & mask)) o.code = mkcl_pkg::MATCH_OPEN;
                    else if (window == (admin_code & mask)) o.code = mkcl_pkg::MATCH_ADMIN;
                end
                last_dash = o.dash;
                o.beep    = (blen != 0);
                if (blen > 1) begin
                    ticks = blen - 1'b1;
                    phase = mkcl_pkg::PH_BEEP;
                end else begin
                    ticks = '0;
                    phase = o.dash ? mkcl_pkg::PH_RELEASE : mkcl_pkg::PH_IDLE;
                end
            end
            o.window = window;
            pending.push_back(o);
        endfunction

        function void compare_field(string name, logic [WIN_W-1:0] want, logic [WIN_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h got %h", $time, name, want, got);
                errors++;
            end
        endfunction

        function void check_tick(logic [OUT_TDATA_W-1:0] td);
            t_tick_out want;
            if (pending.size() == 0) begin
                $display("%0t: result %h arrived with nothing outstanding", $time, td);
                errors++;
                return;
            end
            want = pending.pop_front();
            ticks_checked++;
            if (want.symbol) begin
                if (want.dash) dashes++;
                else dots++;
            end
            if (want.code == mkcl_pkg::MATCH_OPEN) opens++;
            if (want.code == mkcl_pkg::MATCH_ADMIN) admins++;
            compare_field("beep_on", WIN_W'(want.beep), WIN_W'(td[0]));
            compare_field("symbol_valid", WIN_W'(want.symbol), WIN_W'(td[1]));
            compare_field("symbol_is_dash", WIN_W'(want.dash), WIN_W'(td[2]));
            compare_field("match_code", WIN_W'(want.code), WIN_W'(td[4:3]));
            compare_field("window_bits", want.window, td[20:5]);
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    // [0] key_down, [7:1] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    // [0] beep_on, [1] symbol_valid, [2] symbol_is_dash, [4:3] match_code,
    // [20:5] window_bits, [23:21] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    lock_scoreboard sb = new;
    int unsigned    items_sent = 0;
    int unsigned    idle_mode = 0;
    int unsigned    sessions = 0;
    int unsigned    src_idle_pct[3] = '{38, 70, 0};
    int unsigned    sink_idle_pct[3] = '{70, 38, 0};

    morse_key_code_lock dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic bit coin(int unsigned pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    task automatic send_key(input logic key);
        while (coin(src_idle_pct[idle_mode])) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W-1){1'b0}}, key};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_key(key);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic settle_block();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge i_clk);
    endtask

    task automatic cfg_close();
        i_cfg_we <= 1'b0;
    endtask

    task automatic key_symbol(input logic dash);
        int unsigned held, tail;
        if (dash) held = 1 + sb.noise_len + sb.dash_limit + 1;
        else if (coin(25)) held = 1 + sb.noise_len + sb.dash_limit;
        else held = 1 + sb.noise_len + $urandom_range(0, sb.dash_limit);
        repeat (held) send_key(1'b1);
        if (dash) begin
            tail = (sb.dash_beep > 1 ? sb.dash_beep - 1 : 0) + $urandom_range(0, 2);
            repeat (tail) send_key(1'b1);
            repeat (1 + $urandom_range(0, 2)) send_key(1'b0);
        end else begin
            tail = (sb.dot_beep > 0 ? sb.dot_beep : 1) + $urandom_range(0, 2);
            repeat (tail) send_key(1'b0);
        end
    endtask

    task automatic key_code();
        int unsigned      span, pick, i;
        logic [WIN_W-1:0] pattern;
        span = sb.code_span();
        pick = $urandom_range(0, 2);
        pattern = (pick == 0) ? sb.open_code : (pick == 1) ? sb.admin_code : WIN_W'($urandom);
        for (i = span; i > 0; i--) key_symbol(pattern[i-1] ^ coin(5));
    endtask

    task automatic key_noise();
        repeat ($urandom_range(1, 12)) send_key(coin(50));
        repeat (sb.noise_len + sb.dot_beep + sb.dash_beep + 3) send_key(1'b0);
    endtask

    task automatic shuffle_settings(input bit every);
        if (every || coin(70)) cfg_write(mkcl_pkg::REG_OPEN_PATTERN, CFG_DATA_W'($urandom));
        if (every || coin(70)) cfg_write(mkcl_pkg::REG_ADMIN_PATTERN, CFG_DATA_W'($urandom));
        if (every || coin(70)) begin
            if (coin(60)) begin
                cfg_write(mkcl_pkg::REG_CODE_LENGTH, CFG_DATA_W'($urandom_range(1, 5)));
            end else if (coin(15)) begin
                cfg_write(mkcl_pkg::REG_CODE_LENGTH, CFG_DATA_W'($urandom));
            end else begin
                cfg_write(mkcl_pkg::REG_CODE_LENGTH, CFG_DATA_W'($urandom_range(0, 31)));
            end
        end
        if (every || coin(70)) begin
            cfg_write(mkcl_pkg::REG_DASH_TICKS, CFG_DATA_W'($urandom_range(0, 6)));
        end
        if (every || coin(70)) begin
            if (coin(15)) begin
                cfg_write(mkcl_pkg::REG_NOISE_TICKS,
                          {8'($urandom), 8'($urandom_range(0, 3))});
            end else begin
                cfg_write(mkcl_pkg::REG_NOISE_TICKS, CFG_DATA_W'($urandom_range(0, 3)));
            end
        end
        if (every || coin(70)) begin
            cfg_write(mkcl_pkg::REG_DOT_BEEP_TICKS, CFG_DATA_W'($urandom_range(0, 5)));
        end
        if (every || coin(70)) begin
            cfg_write(mkcl_pkg::REG_DASH_BEEP_TICKS, CFG_DATA_W'($urandom_range(0, 5)));
        end
        if (coin(20)) cfg_write(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_close();
        sessions++;
    endtask

    task automatic random_session(input int unsigned budget);
        int unsigned mark, pick;
        settle_block();
        shuffle_settings(sessions == 0);
        mark = items_sent;
        while (items_sent - mark < budget) begin
            pick = $urandom_range(0, 9);
            if (pick < 6) key_code();
            else if (pick < 8) key_symbol(coin(50));
            else key_noise();
        end
    endtask

    task automatic directed_checks();
        // No noise window, dash on the first timed tick, no dot beep.
        cfg_write(mkcl_pkg::REG_OPEN_PATTERN, 16'h0001);
        cfg_write(mkcl_pkg::REG_ADMIN_PATTERN, 16'h0000);
        cfg_write(mkcl_pkg::REG_CODE_LENGTH, 16'd1);
        cfg_write(mkcl_pkg::REG_DASH_TICKS, 16'd0);
        cfg_write(mkcl_pkg::REG_NOISE_TICKS, 16'd0);
        cfg_write(mkcl_pkg::REG_DOT_BEEP_TICKS, 16'd0);
        cfg_write(mkcl_pkg::REG_DASH_BEEP_TICKS, 16'd1);
        cfg_write(REG_UNUSED, 16'hFFFF);
        cfg_close();
        send_key(1'b0);
        send_key(1'b1);
        send_key(1'b1);
        send_key(1'b1);
        send_key(1'b0);
        send_key(1'b1);
        send_key(1'b0);
        settle_block();
        // A length of zero acts as one, and with both codes matching the open code wins.
        cfg_write(mkcl_pkg::REG_CODE_LENGTH, 16'd0);
        cfg_write(mkcl_pkg::REG_ADMIN_PATTERN, 16'hFFFF);
        cfg_close();
        send_key(1'b1);
        send_key(1'b1);
        send_key(1'b0);
        settle_block();
        // Release exactly at the dash threshold must give a dot; length 31 acts as 16.
        cfg_write(mkcl_pkg::REG_DASH_TICKS, 16'd2);
        cfg_write(mkcl_pkg::REG_NOISE_TICKS, 16'd1);
        cfg_write(mkcl_pkg::REG_DOT_BEEP_TICKS, 16'd2);
        cfg_write(mkcl_pkg::REG_CODE_LENGTH, 16'd31);
        cfg_close();
        repeat (4) send_key(1'b1);
        repeat (2) send_key(1'b0);
    endtask

    task automatic extreme_runs();
        settle_block();
        cfg_write(mkcl_pkg::REG_NOISE_TICKS, 16'd0);
        cfg_write(mkcl_pkg::REG_DASH_TICKS, 16'hFFFF);
        cfg_write(mkcl_pkg::REG_DOT_BEEP_TICKS, 16'd30);
        cfg_write(mkcl_pkg::REG_DASH_BEEP_TICKS, 16'd30);
        cfg_write(mkcl_pkg::REG_CODE_LENGTH, 16'd16);
        cfg_close();
        // A long press below the threshold, then the threshold drops under the held count.
        repeat (60) send_key(1'b1);
        settle_block();
        cfg_write(mkcl_pkg::REG_DASH_TICKS, 16'd40);
        cfg_close();
        send_key(1'b1);
        repeat (10) send_key(1'b1);
        // A new beep length written mid-beep only applies from the next symbol.
        settle_block();
        cfg_write(mkcl_pkg::REG_DASH_BEEP_TICKS, 16'd2);
        cfg_close();
        repeat (25) send_key(1'b1);
        send_key(1'b0);
        // Long dot beep.
        send_key(1'b1);
        send_key(1'b0);
        repeat (35) send_key(1'b0);
        settle_block();
        cfg_write(mkcl_pkg::REG_NOISE_TICKS, 16'd255);
        cfg_write(mkcl_pkg::REG_DASH_TICKS, 16'd3);
        cfg_write(mkcl_pkg::REG_DOT_BEEP_TICKS, 16'd2);
        cfg_close();
        key_symbol(1'b0);
        settle_block();
        shuffle_settings(1'b1);
    endtask

    initial begin : result_sink
        int unsigned hold_left;
        bit          pressure_done;
        hold_left     = 0;
        pressure_done = 1'b0;
        forever begin
            @(negedge i_clk);
            if (!pressure_done && sb.ticks_checked >= 300) begin
                pressure_done = 1'b1;
                hold_left     = 150;
            end
            if (hold_left != 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= !coin(sink_idle_pct[idle_mode]);
            end
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready) sb.check_tick(m_axis_tdata);
        end
    end

    initial begin : stimulus
        sb.reset();
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;
        directed_checks();
        while (items_sent < ITEM_TARGET) begin
            if (idle_mode == 0 && items_sent >= ITEM_TARGET / 3) begin
                idle_mode = 1;
            end else if (idle_mode == 1 && items_sent >= 2 * ITEM_TARGET / 3) begin
                idle_mode = 2;
                extreme_runs();
            end
            random_session($urandom_range(60, 140));
        end
        settle_block();
        repeat (10) @(negedge i_clk);
        $display("tb: %0d ticks checked over %0d register settings", sb.ticks_checked, sessions);
        $display("tb: %0d dots, %0d dashes, %0d open and %0d admin matches",
                 sb.dots, sb.dashes, sb.opens, sb.admins);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/mkcl_pkg.sv
sv/morse_key_code_lock.sv
tb/sv/morse_key_code_lock_tb.sv
